[design/bn254_field_modexp_core_defines.svh]
// ----------------------------------------------------------------------------
// BN254 modexp core assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BN254_FIELD_MODEXP_CORE_DEFINES_SVH
`define BN254_FIELD_MODEXP_CORE_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define BFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfm check failed: next-cycle implication");

// Antecedent implies consequent in the same cycle.
`define BFM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfm check failed: same-cycle implication");

`endif

[design/bfm_pkg.sv]
// ----------------------------------------------------------------------------
// BN254 modexp package
// Field constants, controller states and controller/datapath command types.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int LIMB_W = 64;
  localparam int WORD_W = 256;
  localparam int STEP_W = 8;
  localparam int CNT_W  = 8;

  localparam logic [WORD_W-1:0] MOD_P = {
    64'h30644e72e131a029, 64'hb85045b68181585d,
    64'h97816a916871ca8d, 64'h3c208c16d87cfd47
  };

  localparam logic [WORD_W-1:0] MONT_ONE = {
    64'h0e0a77c19a07df2f, 64'h666ea36f7879462c,
    64'h0a78eb28f5c70b3d, 64'hd35d438dc58f0d9d
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_SCAN,
    ST_SQ,
    ST_SQ_RUN,
    ST_SQ_FIN,
    ST_MU,
    ST_MU_RUN,
    ST_MU_FIN,
    ST_NEXT,
    ST_DONE
  } bfm_state_t;

  typedef struct packed {
    logic load;
    logic red;
    logic shift;
    logic mm_start;
    logic mm_sel_base;
    logic mm_step;
    logic mm_fin;
  } bfm_cmd_t;

  typedef struct packed {
    logic base_ge_p;
    logic exp_msb;
    logic exp_zero;
    logic cnt_zero;
    logic step_last;
  } bfm_stat_t;

endpackage

[design/bfm_if.sv]
// ----------------------------------------------------------------------------
// BN254 modexp channels
// Valid/ready channels for the operand beat and the result beat.
// ----------------------------------------------------------------------------
interface bfm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] base_limb0;
  logic [63:0] base_limb1;
  logic [63:0] base_limb2;
  logic [63:0] base_limb3;
  logic [63:0] exp_limb0;
  logic [63:0] exp_limb1;
  logic [63:0] exp_limb2;
  logic [63:0] exp_limb3;

  modport source (output valid, base_limb0, base_limb1, base_limb2, base_limb3,
                  exp_limb0, exp_limb1, exp_limb2, exp_limb3, input ready);
  modport sink (input valid, base_limb0, base_limb1, base_limb2, base_limb3,
                exp_limb0, exp_limb1, exp_limb2, exp_limb3, output ready);
endinterface

interface bfm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_limb0;
  logic [63:0] result_limb1;
  logic [63:0] result_limb2;
  logic [63:0] result_limb3;

  modport source (output valid, result_limb0, result_limb1, result_limb2,
                  result_limb3, input ready);
  modport sink (input valid, result_limb0, result_limb1, result_limb2,
                result_limb3, output ready);
endinterface

[design/bfm_ctrl.sv]
// ----------------------------------------------------------------------------
// BN254 modexp controller
// Sequences base reduction, exponent scan and square/multiply products.
// ----------------------------------------------------------------------------
module bfm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bfm_pkg::bfm_stat_t  stat,
  output bfm_pkg::bfm_cmd_t   cmd
);
  import bfm_pkg::*;

  bfm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_RED;
      ST_RED: begin
        if (!stat.base_ge_p) state_nxt = stat.exp_zero ? ST_DONE : ST_SCAN;
      end
      ST_SCAN:   if (stat.exp_msb || stat.cnt_zero) state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_SQ_RUN;
      ST_SQ_RUN: if (stat.step_last) state_nxt = ST_SQ_FIN;
      ST_SQ_FIN: state_nxt = stat.exp_msb ? ST_MU : ST_NEXT;
      ST_MU:     state_nxt = ST_MU_RUN;
      ST_MU_RUN: if (stat.step_last) state_nxt = ST_MU_FIN;
      ST_MU_FIN: state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = stat.cnt_zero ? ST_DONE : ST_SQ;
      ST_DONE:   if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RED:    cmd.red = stat.base_ge_p;
      ST_SCAN:   cmd.shift = !(stat.exp_msb || stat.cnt_zero);
      ST_SQ:     cmd.mm_start = 1'b1;
      ST_SQ_RUN: cmd.mm_step = 1'b1;
      ST_SQ_FIN: cmd.mm_fin = 1'b1;
      ST_MU: begin
        cmd.mm_start    = 1'b1;
        cmd.mm_sel_base = 1'b1;
      end
      ST_MU_RUN: cmd.mm_step = 1'b1;
      ST_MU_FIN: cmd.mm_fin = 1'b1;
      ST_NEXT:   cmd.shift = !stat.cnt_zero;
      ST_DONE:   out_valid = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

[design/bfm_dp.sv]
// ----------------------------------------------------------------------------
// BN254 modexp datapath
// Operand registers, exponent shifter and radix-2 Montgomery product unit.
// ----------------------------------------------------------------------------
module bfm_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bfm_pkg::bfm_cmd_t                 cmd,
  output bfm_pkg::bfm_stat_t                stat,
  input  logic [bfm_pkg::WORD_W-1:0]        base_in,
  input  logic [bfm_pkg::WORD_W-1:0]        exp_in,
  output logic [bfm_pkg::WORD_W-1:0]        result
);
  import bfm_pkg::*;

  logic [WORD_W-1:0] base_r, base_nxt;
  logic [WORD_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] r_r, r_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W:0]   bp_r, bp_nxt;
  logic [WORD_W-1:0] t_r, t_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [WORD_W:0]   sub_base;
  logic [WORD_W:0]   sub_t;
  logic [WORD_W-1:0] bsel;
  logic              q;
  logic [WORD_W:0]   addend;
  logic [WORD_W:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    r_r    <= r_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    bp_r   <= bp_nxt;
    t_r    <= t_nxt;
  end

  always_comb begin
    sub_base = {1'b0, base_r} - {1'b0, MOD_P};
    sub_t    = {1'b0, t_r} - {1'b0, MOD_P};
    bsel     = cmd.mm_sel_base ? base_r : r_r;
    q        = t_r[0] ^ (a_r[0] & b_r[0]);
    if (a_r[0]) begin
      addend = q ? bp_r : {1'b0, b_r};
    end else begin
      addend = q ? {1'b0, MOD_P} : '0;
    end
    sum = {1'b0, t_r} + addend;
  end

  always_comb begin
    base_nxt = base_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    bp_nxt   = bp_r;
    t_nxt    = t_r;
    step_nxt = step_r;
    if (cmd.load) begin
      base_nxt = base_in;
      exp_nxt  = exp_in;
      cnt_nxt  = '1;
      r_nxt    = MONT_ONE;
    end
    if (cmd.red) begin
      base_nxt = sub_base[WORD_W-1:0];
    end
    if (cmd.shift) begin
      exp_nxt = {exp_r[WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.mm_start) begin
      a_nxt    = r_r;
      b_nxt    = bsel;
      bp_nxt   = {1'b0, bsel} + {1'b0, MOD_P};
      t_nxt    = '0;
      step_nxt = '0;
    end
    if (cmd.mm_step) begin
      a_nxt    = {1'b0, a_r[WORD_W-1:1]};
      t_nxt    = sum[WORD_W:1];
      step_nxt = step_r + 1'b1;
    end
    if (cmd.mm_fin) begin
      r_nxt = sub_t[WORD_W] ? t_r : sub_t[WORD_W-1:0];
    end
  end

  always_comb begin
    stat.base_ge_p = !sub_base[WORD_W];
    stat.exp_msb   = exp_r[WORD_W-1];
    stat.exp_zero  = ~|exp_r;
    stat.cnt_zero  = (cnt_r == '0);
    stat.step_last = (step_r == '1);
  end

  assign result = r_r;

endmodule

[design/bn254_field_modexp_core.sv]
// Flow: repeated subtraction reduces the base below p, a scan skips leading
// zero exponent bits, then each bit takes a Montgomery square, a multiply when
// set and an advance; a product is a setup, 256 radix-2 steps on one 257-bit
// adder and a final subtract, at most 512 products in all.
// Throughput: one beat in flight; the next operand beat is taken after the
// result beat leaves. Reset (synchronous, active low) returns the controller
// to idle; datapath registers other than the step counter are not cleared.
// ----------------------------------------------------------------------------
// BN254 modexp core
// Montgomery-form left-to-right square-and-multiply over the BN254 prime.
// ----------------------------------------------------------------------------
module bn254_field_modexp_core (
  input  logic       clk,
  input  logic       rst_n,
  bfm_in_if.sink     in_ch,
  bfm_out_if.source  out_ch
);
  import bfm_pkg::*;

  bfm_cmd_t          cmd;
  bfm_stat_t         stat;
  logic [WORD_W-1:0] base_in;
  logic [WORD_W-1:0] exp_in;
  logic [WORD_W-1:0] result;

  assign base_in = {in_ch.base_limb3, in_ch.base_limb2, in_ch.base_limb1, in_ch.base_limb0};
  assign exp_in  = {in_ch.exp_limb3, in_ch.exp_limb2, in_ch.exp_limb1, in_ch.exp_limb0};

  bfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfm_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .base_in (base_in),
    .exp_in  (exp_in),
    .result  (result)
  );

  assign out_ch.result_limb0 = result[LIMB_W-1:0];
  assign out_ch.result_limb1 = result[2*LIMB_W-1:LIMB_W];
  assign out_ch.result_limb2 = result[3*LIMB_W-1:2*LIMB_W];
  assign out_ch.result_limb3 = result[4*LIMB_W-1:3*LIMB_W];

endmodule

[design/bfm_checker.sv]
// ----------------------------------------------------------------------------
// BN254 modexp port checker
// Port-level checks on the operand and result beats.
// ----------------------------------------------------------------------------
`include "bn254_field_modexp_core_defines.svh"

module bfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_limb0,
  input logic [63:0] result_limb3
);

  `BFM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `BFM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(result_limb0) && $stable(result_limb3))
  `BFM_ASSERT_SAME(a_one_beat, clk, rst_n, out_valid, !in_ready)
  `BFM_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && in_ready, !out_valid && !in_ready)

endmodule

bind bn254_field_modexp_core bfm_checker u_bfm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_limb0 (out_ch.result_limb0),
  .result_limb3 (out_ch.result_limb3)
);
